// ===== hw/rtl/triangle_tangent_generator_defines.svh =====
// Assertion macros used by the tangent generator back unit.
`ifndef TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH
`define TRIANGLE_TANGENT_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define TTG_ASSERT(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("tangent generator assertion failed");
`define TTG_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) \
        else $error("tangent generator assertion failed");
`else
`define TTG_ASSERT(lbl, ck, rstn, prop)
`define TTG_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

// ===== hw/rtl/ttg_pkg.sv =====
`timescale 1ns / 1ps
package ttg_pkg;

    // Fields of one vertex and number of differences per triangle.
    localparam int FIELDS      = 5;
    localparam int DIFF_FIELDS = 10;

    // Places of the differences in a triangle word.
    localparam int IDX_E10  = 0;
    localparam int IDX_E20  = 3;
    localparam int IDX_DU10 = 6;
    localparam int IDX_DV10 = 7;
    localparam int IDX_DU20 = 8;
    localparam int IDX_DV20 = 9;

    // Depth of the triangle queue between front and back.
    localparam int Q_DEPTH = 2;

    // Normalised magnitudes have their top bit here.
    localparam int NORM_TOP = 29;
    // Width of the sum of squares and of the square root unit.
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;

    // Beats emitted per triangle.
    localparam logic [1:0] TRI_BEATS = 2'd3;

endpackage

// ===== hw/rtl/ttg_interfaces.sv =====
`timescale 1ns / 1ps
// Vertex channel.
interface ttg_vertex_if #(parameter int CW = 24);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] tex_u;
    logic signed [CW-1:0] tex_v;
    logic                 end_of_mesh;

    modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, end_of_mesh,
                   input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, end_of_mesh,
                 output ready);
endinterface

// Tangent channel.
interface ttg_tangent_if #(parameter int OW = 18);
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] tangent_x;
    logic signed [OW-1:0] tangent_y;
    logic signed [OW-1:0] tangent_z;
    logic                 degenerate;
    logic                 last_of_triangle;

    modport source(output valid, tangent_x, tangent_y, tangent_z, degenerate,
                   last_of_triangle, input ready);
    modport sink(input valid, tangent_x, tangent_y, tangent_z, degenerate,
                 last_of_triangle, output ready);
endinterface

// ===== hw/rtl/ttg_front.sv =====
`timescale 1ns / 1ps
module ttg_front #(
    parameter int CW = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    ttg_vertex_if.sink                               vertex,
    output logic                                     tri_valid,
    input  logic                                     tri_ready,
    output logic [ttg_pkg::DIFF_FIELDS*(CW+1)-1:0]   tri_data
);

    localparam int D = CW + 1;
    localparam logic [1:0] SLOT_V0 = 2'd0;
    localparam logic [1:0] SLOT_V1 = 2'd1;
    localparam logic [1:0] SLOT_V2 = 2'd2;

    logic [1:0]           slot_reg, slot_next;
    logic [1:0]           slot_eff;
    logic                 third;
    logic                 accept;
    logic signed [CW-1:0] held_reg [2][ttg_pkg::FIELDS];
    logic signed [CW-1:0] cur [ttg_pkg::FIELDS];

    // Current vertex as an array of fields.
    assign cur[0] = vertex.pos_x;
    assign cur[1] = vertex.pos_y;
    assign cur[2] = vertex.pos_z;
    assign cur[3] = vertex.tex_u;
    assign cur[4] = vertex.tex_v;

    // The unused slot code behaves as the first vertex.
    assign slot_eff = (slot_reg == SLOT_V2 || slot_reg == SLOT_V1) ? slot_reg : SLOT_V0;
    assign third    = (slot_eff == SLOT_V2) && !vertex.end_of_mesh;

    // A third vertex waits for room in the queue; everything else is taken at once.
    assign tri_valid    = vertex.valid && third;
    assign vertex.ready = third ? tri_ready : 1'b1;
    assign accept       = vertex.valid && vertex.ready;

    // Slot sequencing.
    always_comb
    begin
        slot_next = slot_reg;
        if (accept)
        begin
            if (vertex.end_of_mesh || third)
                slot_next = SLOT_V0;
            else
                slot_next = slot_eff + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= SLOT_V0;
        else
            slot_reg <= slot_next;
    end

    // Hold the first two vertices.
    always_ff @(posedge clk)
    begin
        if (accept && !vertex.end_of_mesh && !third)
        begin
            for (int i = 0; i < ttg_pkg::FIELDS; i++)
                held_reg[slot_eff[0]][i] <= cur[i];
        end
    end

    // Edge and texture differences of the completed triangle.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tri_data[(ttg_pkg::IDX_E10 + i)*D +: D] = D'(held_reg[1][i]) - D'(held_reg[0][i]);
            tri_data[(ttg_pkg::IDX_E20 + i)*D +: D] = D'(cur[i]) - D'(held_reg[0][i]);
        end
        tri_data[ttg_pkg::IDX_DU10*D +: D] = D'(held_reg[1][3]) - D'(held_reg[0][3]);
        tri_data[ttg_pkg::IDX_DV10*D +: D] = D'(held_reg[1][4]) - D'(held_reg[0][4]);
        tri_data[ttg_pkg::IDX_DU20*D +: D] = D'(cur[3]) - D'(held_reg[0][3]);
        tri_data[ttg_pkg::IDX_DV20*D +: D] = D'(cur[4]) - D'(held_reg[0][4]);
    end

endmodule

// ===== hw/rtl/ttg_fifo.sv =====
`timescale 1ns / 1ps
module ttg_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          push, pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + NW'(1);
            else if (pop && !push)
                count_reg <= count_reg - NW'(1);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/ttg_back.sv =====
`timescale 1ns / 1ps
`include "triangle_tangent_generator_defines.svh"
module ttg_back #(
    parameter int CW  = 24,
    parameter int OFB = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   tri_valid,
    output logic                                   tri_ready,
    input  logic [ttg_pkg::DIFF_FIELDS*(CW+1)-1:0] tri_data,
    ttg_tangent_if.source                          tangent
);

    localparam int D    = CW + 1;
    localparam int OPW  = (D > 31) ? D : 31;
    localparam int PRW  = 2 * OPW;
    localparam int MAGW = 2 * D;
    localparam int OW   = OFB + 2;
    localparam int QW   = OFB + 2;
    localparam int NT   = ttg_pkg::NORM_TOP;
    localparam int DW   = NT + 3 + OFB;
    localparam int SW   = ttg_pkg::SUM_W;
    localparam int RW   = ttg_pkg::ROOT_W;
    localparam int STW  = $clog2(OFB + 2);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_A    = 4'd1;
    localparam logic [3:0] ST_MUL_B    = 4'd2;
    localparam logic [3:0] ST_DIFF     = 4'd3;
    localparam logic [3:0] ST_NORM     = 4'd4;
    localparam logic [3:0] ST_SQ_A     = 4'd5;
    localparam logic [3:0] ST_SQ_B     = 4'd6;
    localparam logic [3:0] ST_SQRT     = 4'd7;
    localparam logic [3:0] ST_DIV_INIT = 4'd8;
    localparam logic [3:0] ST_DIV      = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [1:0]            k_reg, k_next;
    logic [1:0]            ocnt_reg;
    logic signed [D-1:0]   f_reg [ttg_pkg::DIFF_FIELDS];
    logic signed [PRW-1:0] pa_reg, pb_reg;
    logic                  dneg_reg;
    logic [2:0]            neg_reg;
    logic [MAGW-1:0]       mag_reg [3];
    logic [SW-1:0]         sum_reg, res_reg, bit_reg;
    logic [DW-1:0]         rem_reg, div_reg;
    logic [QW-1:0]         q_reg;
    logic [STW-1:0]        step_reg;
    logic signed [OW-1:0]  comp_reg [3];
    logic                  degen_reg;
    logic signed [OW-1:0]  ox_reg, oy_reg, oz_reg;
    logic                  odeg_reg;

    logic signed [OPW-1:0] mul_a, mul_b;
    logic signed [PRW-1:0] prod;
    logic signed [PRW:0]   diffv, absd;
    logic                  isneg;
    logic signed [D-1:0]   e10_k, e20_k;
    logic [MAGW-1:0]       mag_k, comb;
    logic                  neg_k;
    logic                  above, norm_ok;
    logic [SW-1:0]         trial;
    logic                  root_ge;
    logic [RW-1:0]         len;
    logic [DW-1:0]         num;
    logic                  div_ge;
    logic [QW-1:0]         q_final, q_clamp;
    logic signed [OW-1:0]  comp;
    logic                  div_last;
    logic                  load_out;

    assign tri_ready = (state_reg == ST_IDLE);

    // Operands chosen by the current component index.
    always_comb
    begin
        e10_k = '0;
        e20_k = '0;
        mag_k = '0;
        neg_k = 1'b0;
        case (k_reg)
            2'd1:
            begin
                e10_k = f_reg[ttg_pkg::IDX_E10];
                e20_k = f_reg[ttg_pkg::IDX_E20];
            end
            2'd2:
            begin
                e10_k = f_reg[ttg_pkg::IDX_E10 + 1];
                e20_k = f_reg[ttg_pkg::IDX_E20 + 1];
            end
            2'd3:
            begin
                e10_k = f_reg[ttg_pkg::IDX_E10 + 2];
                e20_k = f_reg[ttg_pkg::IDX_E20 + 2];
            end
            default:
            begin
            end
        endcase
        case (k_reg)
            2'd0:
            begin
                mag_k = mag_reg[0];
                neg_k = neg_reg[0];
            end
            2'd1:
            begin
                mag_k = mag_reg[1];
                neg_k = neg_reg[1];
            end
            2'd2:
            begin
                mag_k = mag_reg[2];
                neg_k = neg_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    // The one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_A:
            begin
                mul_a = (k_reg == 2'd0) ? OPW'(f_reg[ttg_pkg::IDX_DU20]) : OPW'(e20_k);
                mul_b = OPW'(f_reg[ttg_pkg::IDX_DV10]);
            end
            ST_MUL_B:
            begin
                mul_a = (k_reg == 2'd0) ? OPW'(f_reg[ttg_pkg::IDX_DV20]) : OPW'(e10_k);
                mul_b = (k_reg == 2'd0) ? OPW'(f_reg[ttg_pkg::IDX_DU10])
                                        : OPW'(f_reg[ttg_pkg::IDX_DV20]);
            end
            ST_SQ_A:
            begin
                mul_a = signed'(OPW'(mag_k[NT:0]));
                mul_b = signed'(OPW'(mag_k[NT:0]));
            end
            default:
            begin
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Difference of the two registered products and its magnitude.
    assign diffv = (PRW+1)'(pa_reg) - (PRW+1)'(pb_reg);
    assign isneg = diffv[PRW];
    assign absd  = isneg ? -diffv : diffv;

    // Normalisation tests over all three magnitudes.
    assign comb    = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign above   = |(comb >> (NT + 1));
    assign norm_ok = comb[NT] && !above;

    // Square root step.
    assign trial   = res_reg + bit_reg;
    assign root_ge = (sum_reg >= trial);
    assign len     = res_reg[RW-1:0];

    // Division step with rounding, clamp and sign.
    assign num      = (DW'(mag_k[NT:0]) << OFB) + DW'(len >> 1);
    assign div_ge   = (rem_reg >= div_reg);
    assign q_final  = {q_reg[QW-2:0], div_ge};
    assign q_clamp  = (q_final > (QW'(1) << OFB)) ? (QW'(1) << OFB) : q_final;
    assign comp     = neg_k ? -signed'(q_clamp) : signed'(q_clamp);
    assign div_last = (step_reg == STW'(OFB + 1));
    assign load_out = (state_reg == ST_DONE) && (ocnt_reg == 2'd0);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tri_valid)
                begin
                    state_next = ST_MUL_A;
                    k_next     = 2'd0;
                end
            end
            ST_MUL_A: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_DIFF;
            ST_DIFF:
            begin
                if (k_reg == 2'd3)
                    state_next = ST_NORM;
                else
                begin
                    state_next = ST_MUL_A;
                    k_next     = k_reg + 2'd1;
                end
            end
            ST_NORM:
            begin
                if (comb == '0)
                    state_next = ST_DONE;
                else if (norm_ok)
                begin
                    state_next = ST_SQ_A;
                    k_next     = 2'd0;
                end
            end
            ST_SQ_A: state_next = ST_SQ_B;
            ST_SQ_B:
            begin
                if (k_reg == 2'd2)
                    state_next = ST_SQRT;
                else
                begin
                    state_next = ST_SQ_A;
                    k_next     = k_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                if (bit_reg == SW'(1))
                begin
                    state_next = ST_DIV_INIT;
                    k_next     = 2'd0;
                end
            end
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                begin
                    if (k_reg == 2'd2)
                        state_next = ST_DONE;
                    else
                    begin
                        state_next = ST_DIV_INIT;
                        k_next     = k_reg + 2'd1;
                    end
                end
            end
            ST_DONE:
            begin
                if (ocnt_reg == 2'd0)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (load_out)
                ocnt_reg <= ttg_pkg::TRI_BEATS;
            else if (tangent.valid && tangent.ready)
                ocnt_reg <= ocnt_reg - 2'd1;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (tri_valid)
                begin
                    for (int i = 0; i < ttg_pkg::DIFF_FIELDS; i++)
                        f_reg[i] <= signed'(tri_data[i*D +: D]);
                    sum_reg   <= '0;
                    degen_reg <= 1'b0;
                end
            end
            ST_MUL_A: pa_reg <= prod;
            ST_MUL_B: pb_reg <= prod;
            ST_DIFF:
            begin
                if (k_reg == 2'd0)
                    dneg_reg <= isneg;
                else
                begin
                    mag_reg[k_reg - 2'd1] <= MAGW'(absd);
                    neg_reg[k_reg - 2'd1] <= (|absd) && (isneg != dneg_reg);
                end
            end
            ST_NORM:
            begin
                if (comb == '0)
                begin
                    degen_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                        comp_reg[i] <= '0;
                end
                else if (above)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!comb[NT])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            ST_SQ_A: pa_reg <= prod;
            ST_SQ_B:
            begin
                sum_reg <= sum_reg + SW'(pa_reg);
                res_reg <= '0;
                bit_reg <= SW'(1) << (SW - 2);
            end
            ST_SQRT:
            begin
                if (root_ge)
                begin
                    sum_reg <= sum_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            ST_DIV_INIT:
            begin
                rem_reg  <= num;
                div_reg  <= DW'(len) << (OFB + 1);
                q_reg    <= '0;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                if (div_ge)
                    rem_reg <= rem_reg - div_reg;
                q_reg    <= q_final;
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg + STW'(1);
                if (div_last)
                    comp_reg[k_reg] <= comp;
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            ox_reg   <= comp_reg[0];
            oy_reg   <= comp_reg[1];
            oz_reg   <= comp_reg[2];
            odeg_reg <= degen_reg;
        end
    end

    // Output register: one triangle's tangent repeated over three beats.
    assign tangent.valid            = (ocnt_reg != 2'd0);
    assign tangent.last_of_triangle = (ocnt_reg == 2'd1);
    assign tangent.tangent_x        = ox_reg;
    assign tangent.tangent_y        = oy_reg;
    assign tangent.tangent_z        = oz_reg;
    assign tangent.degenerate       = odeg_reg;

    `TTG_ASSERT(a_degen_zero, clk, rst_n, tangent.valid && tangent.degenerate |-> tangent.tangent_x == '0 && tangent.tangent_y == '0 && tangent.tangent_z == '0)
    `TTG_ASSERT(a_last_empties, clk, rst_n, tangent.valid && tangent.ready && tangent.last_of_triangle |=> !tangent.valid)
    `TTG_ASSERT(a_len_nonzero, clk, rst_n, state_reg == ST_DIV_INIT |-> res_reg != '0)
    `TTG_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !tangent.valid)

endmodule

// ===== hw/rtl/triangle_tangent_generator.sv =====
`timescale 1ns / 1ps
// Per-triangle tangent generator.
// The vertex channel takes one vertex per beat: position and texture
// coordinate in signed Q8.16, or an end-of-mesh beat that drops a partial
// triangle. The tangent channel gives the unit tangent in signed Q2.16 three
// times per triangle, the third beat marked last_of_triangle; a zero-length
// tangent gives zeros with degenerate set.
// The first two vertices of a triangle are taken at once. The third
// is taken at once while the two-entry triangle queue has room, so the
// front keeps taking vertices while the back unit computes.
// The back unit works on one triangle at a time with one shared multiplier:
// products, then one-bit normalising shifts, squares, a bit-serial square
// root and three divisions. When the receiver stalls, the three beats wait
// in the output register; the back unit then stalls on its next result and
// the queue fills, after which third vertices wait. Reset empties the queue,
// clears the vertex slot and drops all pending beats.
module triangle_tangent_generator #(
    parameter int COORD_WIDTH   = 24,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ttg_vertex_if.sink    vertex,
    ttg_tangent_if.source tangent
);

    localparam int TW = ttg_pkg::DIFF_FIELDS * (COORD_WIDTH + 1);

    logic          front_valid, front_ready;
    logic [TW-1:0] front_data;
    logic          back_valid, back_ready;
    logic [TW-1:0] back_data;

    ttg_front #(.CW(COORD_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertex    (vertex),
        .tri_valid (front_valid),
        .tri_ready (front_ready),
        .tri_data  (front_data)
    );

    ttg_fifo #(.W(TW), .DEPTH(ttg_pkg::Q_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_data),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_data)
    );

    ttg_back #(.CW(COORD_WIDTH), .OFB(OUT_FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (back_valid),
        .tri_ready (back_ready),
        .tri_data  (back_data),
        .tangent   (tangent)
    );

endmodule
